>>> rtl/sfr_pkg.sv
package sfr_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SLOT_MAX  = CFG_W / BYTE_W;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_ADR_W = 2;

  // parameter defaults
  localparam int unsigned MAX_PATTERN_DEF     = 8;
  localparam int unsigned MAX_REPLACEMENT_DEF = 8;

  localparam logic [CNT_W-1:0] NO_MATCH  = '1;
  localparam logic [CNT_W-1:0] FIRST_MAX = 32'h7FFF_FFFF;

  typedef enum logic [CFG_ADR_W-1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_REPL        = 2'd2,
    REG_REPL_LEN    = 2'd3
  } cfg_reg_t;

  // one classified item, handed from front to back
  typedef struct packed {
    logic              evict;
    logic [BYTE_W-1:0] evict_byte;
    logic [CNT_W-1:0]  old_total;
    logic [CNT_W-1:0]  old_first;
    logic [LEN_W-1:0]  repl_cnt;
    logic [LEN_W-1:0]  flush_cnt;
    logic [CFG_W-1:0]  flush_bytes;
    logic [CNT_W-1:0]  new_total;
    logic [CNT_W-1:0]  new_first;
    logic              last;
  } sfr_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sfr_q_stat_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

>>> rtl/sfr_front.sv
module sfr_front #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [sfr_pkg::BYTE_W-1:0]        in_byte,
  input  logic                              in_last,
  input  logic [sfr_pkg::CFG_W-1:0]         pattern_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]         pattern_length,
  input  logic [sfr_pkg::LEN_W-1:0]         replacement_length,
  output sfr_pkg::sfr_cmd_t                 cmd
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned BW     = sfr_pkg::BYTE_W;
  localparam int unsigned LW     = sfr_pkg::LEN_W;
  localparam int unsigned CW     = sfr_pkg::CNT_W;

  logic [BW-1:0]     window_r [MAX_PATTERN];
  logic [BW-1:0]     win_nxt  [MAX_PATTERN];
  logic [FILL_W-1:0] fill_r;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     total_r;
  logic [CW-1:0]     first_r;
  logic [LW-1:0]     len_r;

  logic [LW-1:0]     len;
  logic [LW-1:0]     fill_a;
  logic [LW-1:0]     fill_c;
  logic              evict;
  logic [BW-1:0]     evict_byte;
  logic              same;
  logic              match;
  logic [CW-1:0]     new_total;
  logic [CW-1:0]     new_first;
  logic [CW-1:0]     start_at;
  logic [sfr_pkg::CFG_W-1:0] flush_bytes;

  always_comb begin
    if ((pos_r == '0) && (fill_r == '0)) begin
      len = sfr_pkg::clamp_len(pattern_length, LW'(MAX_PATTERN));
    end else begin
      len = len_r;
    end
    win_nxt    = window_r;
    fill_a     = LW'(fill_r);
    evict      = 1'b0;
    evict_byte = '0;
    same       = 1'b1;
    match      = 1'b0;
    if (len == '0) begin
      evict      = 1'b1;
      evict_byte = in_byte;
    end else begin
      if (fill_a >= len) begin
        evict      = 1'b1;
        evict_byte = window_r[0];
        for (int i = 0; i < int'(MAX_PATTERN) - 1; i++) begin
          win_nxt[i] = window_r[i+1];
        end
        fill_a = fill_a - 1'b1;
      end
      for (int i = 0; i < int'(MAX_PATTERN); i++) begin
        if (LW'(i) == fill_a) begin
          win_nxt[i] = in_byte;
        end
      end
      if (fill_a < LW'(MAX_PATTERN)) begin
        fill_a = fill_a + 1'b1;
      end
      for (int i = 0; i < int'(MAX_PATTERN); i++) begin
        if ((LW'(i) < len) && (win_nxt[i] != pattern_bytes[i*BW +: BW])) begin
          same = 1'b0;
        end
      end
      match = (fill_a == len) && same;
    end

    // counters after this item, used by replacement and flush bytes
    new_total = total_r;
    new_first = first_r;
    start_at  = pos_r + 1'b1 - CW'(len);
    if (match) begin
      if (total_r != '1) begin
        new_total = total_r + 1'b1;
      end
      if (first_r == sfr_pkg::NO_MATCH) begin
        new_first = (start_at > sfr_pkg::FIRST_MAX) ? sfr_pkg::FIRST_MAX : start_at;
      end
    end
    fill_c = match ? '0 : fill_a;

    flush_bytes = '0;
    for (int i = 0; i < int'(MAX_PATTERN); i++) begin
      flush_bytes[i*BW +: BW] = win_nxt[i];
    end

    cmd.evict       = evict;
    cmd.evict_byte  = evict_byte;
    cmd.old_total   = total_r;
    cmd.old_first   = first_r;
    cmd.repl_cnt    = match ? sfr_pkg::clamp_len(replacement_length, LW'(MAX_REPLACEMENT))
                            : '0;
    cmd.flush_cnt   = in_last ? fill_c : '0;
    cmd.flush_bytes = flush_bytes;
    cmd.new_total   = new_total;
    cmd.new_first   = new_first;
    cmd.last        = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pos_r   <= '0;
      total_r <= '0;
      first_r <= sfr_pkg::NO_MATCH;
      len_r   <= '0;
    end else if (take) begin
      len_r <= len;
      if (in_last) begin
        fill_r  <= '0;
        pos_r   <= '0;
        total_r <= '0;
        first_r <= sfr_pkg::NO_MATCH;
      end else begin
        fill_r  <= FILL_W'(fill_c);
        pos_r   <= (pos_r == '1) ? pos_r : pos_r + 1'b1;
        total_r <= new_total;
        first_r <= new_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window_r <= win_nxt;
    end
  end

endmodule

>>> rtl/sfr_queue.sv
module sfr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sfr_pkg::sfr_cmd_t     push_cmd,
  input  logic                  pop,
  output sfr_pkg::sfr_cmd_t     head,
  output sfr_pkg::sfr_q_stat_t  stat
);

  sfr_pkg::sfr_cmd_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.empty = (count_r == 2'd0);
  assign stat.full  = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/sfr_back.sv
module sfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfr_pkg::sfr_cmd_t              head,
  input  sfr_pkg::sfr_q_stat_t           stat,
  input  logic [sfr_pkg::CFG_W-1:0]      replacement_bytes,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]     out_byte,
  output logic                           has_byte,
  output logic                           end_of_text,
  output logic [sfr_pkg::CNT_W-1:0]      match_total,
  output logic [sfr_pkg::CNT_W-1:0]      first_match_at
);

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned SW = sfr_pkg::STEP_W;
  localparam int unsigned CW = sfr_pkg::CNT_W;

  logic [SW-1:0] step_r;
  logic          valid_r;
  logic [BW-1:0] byte_r;
  logic          has_r;
  logic          eot_r;
  logic [CW-1:0] total_r;
  logic [CW-1:0] first_r;

  logic [SW-1:0] count;
  logic [SW-1:0] eff;
  logic [SW-1:0] j;
  logic [SW-1:0] f;
  logic          can_load;
  logic          emit;
  logic          final_step;
  logic [BW-1:0] sel_byte;
  logic          sel_has;
  logic [CW-1:0] sel_total;
  logic [CW-1:0] sel_first;

  always_comb begin
    count = SW'(head.evict) + SW'(head.repl_cnt) + SW'(head.flush_cnt);
    eff   = ((count == '0) && head.last) ? SW'(1) : count;
    can_load   = !valid_r || out_ready;
    final_step = (step_r == eff - 1'b1);
    emit = !stat.empty && (eff != '0) && can_load;
    pop  = !stat.empty && ((eff == '0) || (can_load && final_step));

    j = step_r - SW'(head.evict);
    f = j - SW'(head.repl_cnt);
    sel_byte  = '0;
    sel_has   = 1'b1;
    sel_total = head.new_total;
    sel_first = head.new_first;
    if (count == '0) begin
      sel_has = 1'b0;
    end else if (head.evict && (step_r == '0)) begin
      sel_byte  = head.evict_byte;
      sel_total = head.old_total;
      sel_first = head.old_first;
    end else if (j < SW'(head.repl_cnt)) begin
      for (int s = 0; s < int'(sfr_pkg::SLOT_MAX); s++) begin
        if (j == SW'(s)) begin
          sel_byte = replacement_bytes[s*BW +: BW];
        end
      end
    end else begin
      for (int s = 0; s < int'(sfr_pkg::SLOT_MAX); s++) begin
        if (f == SW'(s)) begin
          sel_byte = head.flush_bytes[s*BW +: BW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        step_r <= '0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= sel_byte;
      has_r   <= sel_has;
      eot_r   <= head.last && final_step;
      total_r <= sel_total;
      first_r <= sel_first;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign has_byte       = has_r;
  assign end_of_text    = eot_r;
  assign match_total    = total_r;
  assign first_match_at = first_r;

endmodule

>>> rtl/substring_find_replace_stream_unit.sv
// channel | dir | tdata (low bit up)                              | tuser    | tlast
// in_     | in  | in_byte[7:0]                                    | -        | in_last
// out_    | out | out_byte[7:0], match_total[39:8], first[71:40]  | has_byte | end_of_text
// cfg_    | in  | cfg_addr picks register, cfg_wdata is the value | -        | -
//
// one input byte is taken per cycle while the command queue has room; each byte
// turns into one command that the back end expands into 0..9 output transfers
// at one per cycle while the output is accepted, so throughput is set by the
// back end's output register; a replacement burst stalls the input through the
// two-entry queue. reset (rst_n low, synchronous) clears the window fill,
// counters, queue and output valid; config registers reset to zero
module substring_find_replace_stream_unit #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // in_byte[7:0]
  input  logic                                in_tlast,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [71:0]                         out_tdata,  // out_byte, match_total, first_match_at
  output logic                                out_tuser,  // has_byte
  output logic                                out_tlast,  // end_of_text
  // configuration writes
  input  logic                                cfg_we,
  input  logic [sfr_pkg::CFG_ADR_W-1:0]       cfg_addr,
  input  logic [sfr_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned LW = sfr_pkg::LEN_W;
  localparam int unsigned CW = sfr_pkg::CNT_W;

  // configuration registers
  logic [sfr_pkg::CFG_W-1:0] pattern_r;
  logic [LW-1:0]             pattern_len_r;
  logic [sfr_pkg::CFG_W-1:0] repl_r;
  logic [LW-1:0]             repl_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      pattern_len_r <= '0;
      repl_r        <= '0;
      repl_len_r    <= '0;
    end else if (cfg_we) begin
      unique case (sfr_pkg::cfg_reg_t'(cfg_addr))
        sfr_pkg::REG_PATTERN:     pattern_r     <= cfg_wdata;
        sfr_pkg::REG_PATTERN_LEN: pattern_len_r <= cfg_wdata[LW-1:0];
        sfr_pkg::REG_REPL:        repl_r        <= cfg_wdata;
        sfr_pkg::REG_REPL_LEN:    repl_len_r    <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  sfr_pkg::sfr_cmd_t    front_cmd;
  sfr_pkg::sfr_cmd_t    head_cmd;
  sfr_pkg::sfr_q_stat_t q_stat;
  logic                 take;
  logic                 pop;

  // the input is ready whenever the queue has a free slot
  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;

  // front: window, compare, counters; one command per input byte
  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (take),
    .in_byte            (in_tdata),
    .in_last            (in_tlast),
    .pattern_bytes      (pattern_r),
    .pattern_length     (pattern_len_r),
    .replacement_length (repl_len_r),
    .cmd                (front_cmd)
  );

  // decoupling queue between front and back
  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  logic [BW-1:0] out_byte;
  logic [CW-1:0] match_total;
  logic [CW-1:0] first_match_at;

  // back: expands each command into output transfers
  sfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head_cmd),
    .stat              (q_stat),
    .replacement_bytes (repl_r),
    .pop               (pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_byte          (out_byte),
    .has_byte          (out_tuser),
    .end_of_text       (out_tlast),
    .match_total       (match_total),
    .first_match_at    (first_match_at)
  );

  assign out_tdata = {first_match_at, match_total, out_byte};

endmodule
